// File: design/hgfs_pkg.sv
// Shared constants, register codes and fixed-point helpers for the grid point update.
package hgfs_pkg;

  localparam int unsigned HalfGridDef = 2047;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned DivBits     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegDampPlus  = 4'd0,
    RegDampMinus = 4'd1,
    RegTimeStep  = 4'd2,
    RegCoupling  = 4'd3,
    RegField     = 4'd4,
    RegSpacing   = 4'd5,
    RegDriveNow  = 4'd6,
    RegDriveNext = 4'd7
  } reg_idx_e;

  localparam logic signed [31:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = SatMax;
    end else if (v < -66'sd2147483648) begin
      r = SatMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q16.48 to Q16.24, round half up
  function automatic logic signed [39:0] rnd(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd8388608;
    return s[63:24];
  endfunction

endpackage

// File: design/harmonic_grid_forward_step_top.sv
// Pipelined grid point update: next cosine and sine coefficients for one time step.
// Throughput: one point per cycle; busy stays low, the result path cannot stall.
// The two 63 by 31 bit dividers resolve one quotient bit per stage over 32 stages.
// Reset clears the pipeline valid bits and loads the register reset values.
// Results appear for one cycle with out_valid_o; the receiver cannot hold them off.
module harmonic_grid_forward_step_top #(
  parameter int unsigned HALF_GRID = hgfs_pkg::HalfGridDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [4:0]                       harmonic_i,
  input  logic [11:0]                      row_i,
  input  logic signed [31:0]               equilibrium_i,
  input  logic signed [31:0]               cos_now_i,
  input  logic signed [31:0]               sin_now_i,
  input  logic signed [31:0]               cos_diff_lower_i,
  input  logic signed [31:0]               cos_diff_upper_i,
  input  logic signed [31:0]               sin_diff_lower_i,
  input  logic signed [31:0]               sin_diff_upper_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hgfs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  output logic                             out_valid_o,
  output logic signed [31:0]               cos_next_o,
  output logic signed [31:0]               sin_next_o,
  output logic                             sin_written_o
);
  import hgfs_pkg::*;

  localparam int unsigned OffW = $clog2(HALF_GRID + 4097) + 1;
  localparam int unsigned PhiW = 32 + OffW;

  typedef struct packed {
    logic [30:0] rem;
    logic [31:0] lo;
    logic [31:0] quo;
    logic        neg;
    logic        zero;
  } div_t;

  typedef struct packed {
    logic        npos;
    logic        xi0;
    logic [30:0] xiu;
  } dcom_t;

  logic signed [31:0] nu_q, nut_q, dt_q, bdt_q, bf_q, dphi_q, dn_q, dx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nu_q   <= 32'sd16777216;
      nut_q  <= 32'sd16777216;
      dt_q   <= 32'sd1678;
      bdt_q  <= '0;
      bf_q   <= '0;
      dphi_q <= '0;
      dn_q   <= '0;
      dx_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        RegDampPlus:  nu_q   <= cfg_data_i;
        RegDampMinus: nut_q  <= cfg_data_i;
        RegTimeStep:  dt_q   <= cfg_data_i;
        RegCoupling:  bdt_q  <= cfg_data_i;
        RegField:     bf_q   <= cfg_data_i;
        RegSpacing:   dphi_q <= cfg_data_i;
        RegDriveNow:  dn_q   <= cfg_data_i;
        RegDriveNext: dx_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  logic [8:0] v_q;
  logic       accept;
  assign accept = start && !busy;

  // stage 1: row coordinate product, neighbor differences
  logic signed [OffW-1:0]  off;
  logic signed [31:0]      sl_sel, cl_sel, sd_d, cd_d;
  logic signed [33:0]      cm;
  logic signed [PhiW-1:0]  phi_d;

  always_comb begin
    off    = $signed(OffW'(row_i)) - $signed(OffW'(HALF_GRID + 1));
    phi_d  = PhiW'(dphi_q) * PhiW'(off);
    sl_sel = (harmonic_i < 5'd2) ? 32'sd0 : sin_diff_lower_i;
    cl_sel = (harmonic_i == 5'd0) ? 32'sd0 : cos_diff_lower_i;
    cm     = (harmonic_i == 5'd1) ? (34'(cl_sel) <<< 1) : 34'(cl_sel);
    sd_d   = sat32(66'(sin_diff_upper_i) - 66'(sl_sel));
    cd_d   = sat32(66'(cm) - 66'(cos_diff_upper_i));
  end

  logic [4:0]             n1_q, n2_q, n3_q, n4_q, n5_q, n6_q, n7_q, n8_q, n9_q;
  logic signed [31:0]     a0_1_q, a_1_q, b_1_q, sd_1_q, cd_1_q;
  logic signed [31:0]     a0_2_q, a_2_q, b_2_q, sd_2_q, cd_2_q;
  logic signed [31:0]     a0_3_q, a_3_q, b_3_q, sd_3_q, cd_3_q;
  logic signed [31:0]     a0_4_q, a_4_q, b_4_q, sd_4_q, cd_4_q;
  logic signed [31:0]     a0_5_q, a_5_q, b_5_q, sd_5_q, cd_5_q;
  logic signed [PhiW-1:0] phi_q;
  logic signed [63:0]     bp_q;
  logic signed [31:0]     f0_q, f1_q;
  logic signed [63:0]     fp0_q, fp1_q;
  logic signed [31:0]     mu0_q, mu1_q, mu1_6_q, mu1_7_q;
  logic signed [63:0]     pa0_q, pa_q, pbm_q, psd_q, pbn_q, pam_q, pcd_q, pnn_q, pmm_q;
  logic signed [31:0]     g_q, h_q, xi_q, xi_8_q;
  logic signed [63:0]     pgn_q, phm_q, pgm_q, phn_q;
  logic [64:0]            dc_q, ds_q;
  logic                   negc_q, negs_q, zc_q, zs_q, xi0_q;
  logic [30:0]            xiu_q;

  logic signed [31:0] bphi_d, f0_d, f1_d, mu0_d, mu1_d, g_d, h_d, xi_d;
  logic signed [38:0] t0, t1;
  logic signed [63:0] s0, s1;
  logic signed [64:0] numc, nums;
  logic [64:0]        magc, mags, dc_d, ds_d;

  always_comb begin
    bphi_d = sat32(66'(rnd(bp_q)));
    f0_d   = sat32(66'(dn_q) + 66'(bphi_d));
    f1_d   = sat32(66'(dx_q) + 66'(bphi_d));
    s0     = fp0_q + 64'sd16777216;
    s1     = fp1_q + 64'sd16777216;
    t0     = s0[63:25];
    t1     = s1[63:25];
    mu0_d  = sat32(66'(45'($signed({1'b0, n4_q})) * 45'(t0)));
    mu1_d  = sat32(66'(45'($signed({1'b0, n4_q})) * 45'(t1)));
    g_d    = sat32(66'(rnd(pa0_q)) + 66'(rnd(pa_q)) - 66'(rnd(pbm_q)) + 66'(rnd(psd_q)));
    h_d    = sat32(66'(rnd(pbn_q)) + 66'(rnd(pam_q)) + 66'(rnd(pcd_q)));
    xi_d   = sat32(66'(rnd(pnn_q)) + 66'(rnd(pmm_q)));
    numc   = 65'(pgn_q) - 65'(phm_q);
    nums   = 65'(pgm_q) + 65'(phn_q);
    magc   = numc[64] ? 65'(-numc) : 65'(numc);
    mags   = nums[64] ? 65'(-nums) : 65'(nums);
    dc_d   = magc + 65'(xi_8_q[30:1]);
    ds_d   = mags + 65'(xi_8_q[30:1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[7:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q   <= harmonic_i;
    phi_q  <= phi_d;
    a0_1_q <= equilibrium_i;
    a_1_q  <= cos_now_i;
    b_1_q  <= sin_now_i;
    sd_1_q <= sd_d;
    cd_1_q <= cd_d;

    n2_q   <= n1_q;
    bp_q   <= bf_q * sat32(66'(phi_q));
    {a0_2_q, a_2_q, b_2_q, sd_2_q, cd_2_q} <= {a0_1_q, a_1_q, b_1_q, sd_1_q, cd_1_q};

    n3_q   <= n2_q;
    f0_q   <= f0_d;
    f1_q   <= f1_d;
    {a0_3_q, a_3_q, b_3_q, sd_3_q, cd_3_q} <= {a0_2_q, a_2_q, b_2_q, sd_2_q, cd_2_q};

    n4_q   <= n3_q;
    fp0_q  <= 64'(f0_q) * 64'(dt_q);
    fp1_q  <= 64'(f1_q) * 64'(dt_q);
    {a0_4_q, a_4_q, b_4_q, sd_4_q, cd_4_q} <= {a0_3_q, a_3_q, b_3_q, sd_3_q, cd_3_q};

    n5_q   <= n4_q;
    mu0_q  <= mu0_d;
    mu1_q  <= mu1_d;
    {a0_5_q, a_5_q, b_5_q, sd_5_q, cd_5_q} <= {a0_4_q, a_4_q, b_4_q, sd_4_q, cd_4_q};

    n6_q    <= n5_q;
    mu1_6_q <= mu1_q;
    pa0_q   <= 64'(dt_q) * 64'(a0_5_q);
    pa_q    <= 64'(a_5_q) * 64'(nut_q);
    pbn_q   <= 64'(b_5_q) * 64'(nut_q);
    psd_q   <= 64'(bdt_q) * 64'(sd_5_q);
    pcd_q   <= 64'(bdt_q) * 64'(cd_5_q);
    pnn_q   <= 64'(nu_q) * 64'(nu_q);
    pbm_q   <= 64'(b_5_q) * 64'(mu0_q);
    pam_q   <= 64'(a_5_q) * 64'(mu0_q);
    pmm_q   <= 64'(mu1_q) * 64'(mu1_q);

    n7_q    <= n6_q;
    mu1_7_q <= mu1_6_q;
    g_q     <= g_d;
    h_q     <= h_d;
    xi_q    <= xi_d;

    n8_q    <= n7_q;
    xi_8_q  <= xi_q;
    pgn_q   <= 64'(g_q) * 64'(nu_q);
    phm_q   <= 64'(h_q) * 64'(mu1_7_q);
    pgm_q   <= 64'(g_q) * 64'(mu1_7_q);
    phn_q   <= 64'(h_q) * 64'(nu_q);

    n9_q    <= n8_q;
    dc_q    <= dc_d;
    ds_q    <= ds_d;
    negc_q  <= numc[64];
    negs_q  <= nums[64];
    zc_q    <= (magc == '0);
    zs_q    <= (mags == '0);
    xi0_q   <= xi_8_q[31] || (xi_8_q == '0);
    xiu_q   <= xi_8_q[30:0];
  end

  // divider lanes, one quotient bit per stage
  div_t  cdv_q [DivBits+1];
  div_t  sdv_q [DivBits+1];
  dcom_t dcm_q [DivBits+1];
  logic  dvl_q [DivBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvl_q[0] <= 1'b0;
    end else begin
      dvl_q[0] <= v_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    dcm_q[0].npos        <= (n9_q != 5'd0);
    dcm_q[0].xi0         <= xi0_q;
    dcm_q[0].xiu         <= xiu_q;
    cdv_q[0].rem         <= dc_q[62:32];
    cdv_q[0].lo          <= dc_q[31:0];
    cdv_q[0].quo         <= '0;
    cdv_q[0].neg         <= negc_q;
    cdv_q[0].zero        <= zc_q;
    sdv_q[0].rem         <= ds_q[62:32];
    sdv_q[0].lo          <= ds_q[31:0];
    sdv_q[0].quo         <= '0;
    sdv_q[0].neg         <= negs_q;
    sdv_q[0].zero        <= zs_q;
  end

  for (genvar k = 0; k < DivBits; k++) begin : g_div
    logic [31:0] rc2, rs2, subc, subs;
    logic        gec, ges;
    logic [31:0] xw;
    logic [31:0] qc, qs;
    always_comb begin
      xw   = {1'b0, dcm_q[k].xiu};
      rc2  = {cdv_q[k].rem, cdv_q[k].lo[DivBits-1-k]};
      rs2  = {sdv_q[k].rem, sdv_q[k].lo[DivBits-1-k]};
      gec  = rc2 >= xw;
      ges  = rs2 >= xw;
      subc = rc2 - xw;
      subs = rs2 - xw;
      qc   = cdv_q[k].quo;
      qs   = sdv_q[k].quo;
      qc[DivBits-1-k] = gec;
      qs[DivBits-1-k] = ges;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvl_q[k+1] <= 1'b0;
      end else begin
        dvl_q[k+1] <= dvl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dcm_q[k+1]              <= dcm_q[k];
      cdv_q[k+1].lo           <= cdv_q[k].lo;
      sdv_q[k+1].lo           <= sdv_q[k].lo;
      cdv_q[k+1].neg          <= cdv_q[k].neg;
      sdv_q[k+1].neg          <= sdv_q[k].neg;
      cdv_q[k+1].zero         <= cdv_q[k].zero;
      sdv_q[k+1].zero         <= sdv_q[k].zero;
      cdv_q[k+1].rem          <= gec ? subc[30:0] : rc2[30:0];
      sdv_q[k+1].rem          <= ges ? subs[30:0] : rs2[30:0];
      cdv_q[k+1].quo          <= qc;
      sdv_q[k+1].quo          <= qs;
    end
  end

  function automatic logic signed [31:0] fin(input div_t d, input logic xi0, input logic ovf);
    logic signed [31:0] r;
    if (d.zero) begin
      r = '0;
    end else if (xi0 || ovf) begin
      r = d.neg ? SatMin : SatMax;
    end else if (d.neg) begin
      r = (d.quo > 32'h8000_0000) ? SatMin : -$signed(d.quo);
    end else begin
      r = (d.quo > 32'h7fff_ffff) ? SatMax : $signed(d.quo);
    end
    return r;
  endfunction

  logic ovfc_q [DivBits+1];
  logic ovfs_q [DivBits+1];

  always_ff @(posedge clk_i) begin
    ovfc_q[0] <= dc_q >= 65'({xiu_q, 32'b0});
    ovfs_q[0] <= ds_q >= 65'({xiu_q, 32'b0});
  end

  for (genvar j = 0; j < DivBits; j++) begin : g_ovf
    always_ff @(posedge clk_i) begin
      ovfc_q[j+1] <= ovfc_q[j];
      ovfs_q[j+1] <= ovfs_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= dvl_q[DivBits];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_next_o    <= fin(cdv_q[DivBits], dcm_q[DivBits].xi0, ovfc_q[DivBits]);
    sin_next_o    <= dcm_q[DivBits].npos ?
                     fin(sdv_q[DivBits], dcm_q[DivBits].xi0, ovfs_q[DivBits]) : 32'sd0;
    sin_written_o <= dcm_q[DivBits].npos;
  end

`ifndef NO_ASSERTIONS
  a_sin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sin_written_o) |-> (sin_next_o == 32'sd0))
    else $error("sine result not cleared at zero harmonic");

  a_cos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dvl_q[DivBits] && cdv_q[DivBits].zero) |=> (out_valid_o && cos_next_o == 32'sd0))
    else $error("zero numerator did not give zero cosine result");

  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(dvl_q[DivBits]))
    else $error("result strobe without a transaction in the last divider stage");
`endif

endmodule
